### sv/tsrf_pkg.sv
// ----------------------------------------------------------------------------
// tsrf_pkg: shared types and codes of the touch sample rank filter
// Sample width, window depth, item kind and pen code encodings.
// ----------------------------------------------------------------------------
package tsrf_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int WIN_DEPTH   = 5;
    localparam int HOLD_BITS   = 16;
    localparam int WARM_BITS   = 3;
    localparam int CFG_BITS    = 16;
    localparam int PTR_BITS    = $clog2(WIN_DEPTH);

    // Slot of the sorted window that is reported (second largest)
    localparam int REPORT_SLOT = 3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [WIN_DEPTH-1:0] win_t;
    typedef logic [PTR_BITS-1:0]    ptr_t;
    typedef logic [HOLD_BITS-1:0]   hold_t;
    typedef logic [WARM_BITS-1:0]   warm_t;

    typedef enum logic [1:0] {
        KIND_CONTACT = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PEN_UP    = 2'd0,
        PEN_TOUCH = 2'd1,
        PEN_LONG  = 2'd2,
        PEN_RSVD  = 2'd3
    } pen_code_t;

    typedef enum logic {
        CFG_LONG_HOLD = 1'b0,
        CFG_WARMUP    = 1'b1
    } cfg_index_t;

endpackage

### sv/tsrf_if.sv
// ----------------------------------------------------------------------------
// tsrf_if: valid/ready channels of the touch sample rank filter
// Event channel (kind and raw samples) and report channel.
// ----------------------------------------------------------------------------
interface tsrf_event_if
    import tsrf_pkg::*;
();
    logic    valid;
    logic    ready;
    logic [1:0] kind;
    sample_t sample_x;
    sample_t sample_y;

    modport source (output valid, output kind, output sample_x, output sample_y,
                    input ready);
    modport sink   (input valid, input kind, input sample_x, input sample_y,
                    output ready);
endinterface

interface tsrf_report_if
    import tsrf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t report_x;
    sample_t report_y;
    logic [1:0] pen_code;

    modport source (output valid, output report_x, output report_y, output pen_code,
                    input ready);
    modport sink   (input valid, input report_x, input report_y, input pen_code,
                    output ready);
endinterface

### sv/touch_sample_rank_filter.sv
// ----------------------------------------------------------------------------
// touch_sample_rank_filter: five-sample rank filter for touch coordinates
// Warm-up, pen state, hold timer and second-largest rank report of x and y.
// ----------------------------------------------------------------------------
// Usage
//   events  : valid/ready sink. Each transaction carries kind (contact change,
//             coordinate sample or time tick) plus raw x/y samples.
//   reports : valid/ready source. Zero or one report per event: filtered x/y
//             and pen code (up, down, long hold).
//   cfg_*   : write port; index 0 long-hold tick threshold, index 1 warm-up
//             sample count. Write only while no event is in flight.
// Timing
//   An accepted event is held in the input register; when the stage advances
//   it updates the filter state and loads the report register. One event
//   per cycle is sustained while reports are taken; the state update (window
//   write, sort network, counters) is combinational and does not hold the
//   flow.
// Reset
//   Windows, pointers, counters and pen state clear; thresholds return to
//   75 ticks and 5 samples.
// Stall
//   A report not taken holds the report register; the input register keeps
//   accepting until it too is full, then events.ready drops.
// ----------------------------------------------------------------------------
module touch_sample_rank_filter
    import tsrf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tsrf_event_if.sink          events,
    tsrf_report_if.source       reports,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    // configuration
    hold_t long_hold_reg;
    warm_t warmup_cfg_reg;

    // input register
    logic    ev_valid_reg;
    kind_t   ev_kind_reg;
    sample_t ev_x_reg;
    sample_t ev_y_reg;

    // filter state
    win_t    win_x_reg,    win_x_next;
    win_t    win_y_reg,    win_y_next;
    ptr_t    ring_ptr_reg, ring_ptr_next;
    warm_t   warm_left_reg, warm_left_next;
    logic    contact_reg,  contact_next;
    sample_t last_x_reg,   last_x_next;
    sample_t last_y_reg,   last_y_next;
    hold_t   hold_reg,     hold_next;

    // report register
    logic      rep_valid_reg, rep_valid_next;
    sample_t   rep_x_reg,     rep_x_next;
    sample_t   rep_y_reg,     rep_y_next;
    pen_code_t rep_code_reg,  rep_code_next;

    logic  advance;
    logic  compute;
    logic  emit;
    win_t  win_x_wr, win_y_wr;
    win_t  sort_x, sort_y;
    warm_t warm_dec;
    hold_t hold_eff;

    // advance the work stage whenever the report register is free or draining
    assign advance      = !rep_valid_reg || reports.ready;
    assign events.ready = !ev_valid_reg || advance;
    assign compute      = ev_valid_reg && advance;

    assign reports.valid    = rep_valid_reg;
    assign reports.report_x = rep_x_reg;
    assign reports.report_y = rep_y_reg;
    assign reports.pen_code = rep_code_reg;

    // write the new sample into its slot, then sort both windows
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_x_wr[i] = (ring_ptr_reg == PTR_BITS'(i)) ? ev_x_reg : win_x_reg[i];
            win_y_wr[i] = (ring_ptr_reg == PTR_BITS'(i)) ? ev_y_reg : win_y_reg[i];
        end
    end

    tsrf_sort5 u_sort_x (.din(win_x_wr), .dout(sort_x));
    tsrf_sort5 u_sort_y (.din(win_y_wr), .dout(sort_y));

    assign warm_dec = warm_left_reg - WARM_BITS'(1);

    // state update and report selection for the event in the input register
    always_comb
    begin
        win_x_next     = win_x_reg;
        win_y_next     = win_y_reg;
        ring_ptr_next  = ring_ptr_reg;
        warm_left_next = warm_left_reg;
        contact_next   = contact_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        hold_next      = hold_reg;
        emit           = 1'b0;
        rep_x_next     = rep_x_reg;
        rep_y_next     = rep_y_reg;
        rep_code_next  = rep_code_reg;
        hold_eff       = hold_reg;

        if (compute)
        begin
            case (ev_kind_reg)
                KIND_CONTACT:
                begin
                    if (!contact_reg)
                    begin
                        // touch-down: restart warm-up
                        ring_ptr_next  = '0;
                        warm_left_next = warmup_cfg_reg;
                    end
                    else
                    begin
                        // release: report last position unless still warming up
                        contact_next = 1'b0;
                        if (warm_left_reg == '0)
                        begin
                            emit          = 1'b1;
                            rep_x_next    = last_x_reg;
                            rep_y_next    = last_y_reg;
                            rep_code_next = PEN_UP;
                        end
                    end
                end
                KIND_SAMPLE:
                begin
                    contact_next  = 1'b1;
                    ring_ptr_next = (ring_ptr_reg == PTR_BITS'(WIN_DEPTH - 1)) ?
                                    '0 : ring_ptr_reg + PTR_BITS'(1);
                    win_x_next    = win_x_wr;
                    win_y_next    = win_y_wr;
                    if (warm_left_reg != '0)
                    begin
                        warm_left_next = warm_dec;
                    end
                    if (warm_left_reg == '0 || warm_dec == '0)
                    begin
                        if (warm_left_reg != '0)
                        begin
                            // warm-up just ended: restart the hold timer
                            hold_next = '0;
                            hold_eff  = '0;
                        end
                        win_x_next    = sort_x;
                        win_y_next    = sort_y;
                        last_x_next   = sort_x[REPORT_SLOT];
                        last_y_next   = sort_y[REPORT_SLOT];
                        emit          = 1'b1;
                        rep_x_next    = sort_x[REPORT_SLOT];
                        rep_y_next    = sort_y[REPORT_SLOT];
                        rep_code_next = (hold_eff >= long_hold_reg) ? PEN_LONG : PEN_TOUCH;
                    end
                end
                KIND_TICK:
                begin
                    // saturate at full scale
                    if (hold_reg != '1)
                    begin
                        hold_next = hold_reg + HOLD_BITS'(1);
                    end
                end
                default:
                begin
                    // unused kind: drop
                end
            endcase
        end

        if (compute)
        begin
            rep_valid_next = emit;
        end
        else if (reports.ready)
        begin
            rep_valid_next = 1'b0;
        end
        else
        begin
            rep_valid_next = rep_valid_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg  <= HOLD_BITS'(75);
            warmup_cfg_reg <= WARM_BITS'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LONG_HOLD: long_hold_reg  <= cfg_data[HOLD_BITS-1:0];
                CFG_WARMUP:    warmup_cfg_reg <= cfg_data[WARM_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // input register: load on every transaction, hold while the stage is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            ev_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            ev_kind_reg <= kind_t'(events.kind);
            ev_x_reg    <= events.sample_x;
            ev_y_reg    <= events.sample_y;
        end
    end

    // filter state and report valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg     <= '0;
            win_y_reg     <= '0;
            ring_ptr_reg  <= '0;
            warm_left_reg <= '0;
            contact_reg   <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            hold_reg      <= '0;
            rep_valid_reg <= 1'b0;
        end
        else
        begin
            win_x_reg     <= win_x_next;
            win_y_reg     <= win_y_next;
            ring_ptr_reg  <= ring_ptr_next;
            warm_left_reg <= warm_left_next;
            contact_reg   <= contact_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            hold_reg      <= hold_next;
            rep_valid_reg <= rep_valid_next;
        end
    end

    // report payload
    always_ff @(posedge clk)
    begin
        rep_x_reg    <= rep_x_next;
        rep_y_reg    <= rep_y_next;
        rep_code_reg <= rep_code_next;
    end

endmodule

### sv/tsrf_sort5.sv
// ----------------------------------------------------------------------------
// tsrf_sort5: five-entry ascending sorting network
// Nine compare-exchange cells in six levels, purely combinational.
// ----------------------------------------------------------------------------
module tsrf_sort5
    import tsrf_pkg::*;
(
    input  win_t din,
    output win_t dout
);

    win_t l1, l2, l3, l4, l5;

    always_comb
    begin
        // level 1: (0,1) (3,4)
        l1 = din;
        if (din[0] > din[1])
        begin
            l1[0] = din[1];
            l1[1] = din[0];
        end
        if (din[3] > din[4])
        begin
            l1[3] = din[4];
            l1[4] = din[3];
        end
        // level 2: (2,4)
        l2 = l1;
        if (l1[2] > l1[4])
        begin
            l2[2] = l1[4];
            l2[4] = l1[2];
        end
        // level 3: (2,3) (1,4)
        l3 = l2;
        if (l2[2] > l2[3])
        begin
            l3[2] = l2[3];
            l3[3] = l2[2];
        end
        if (l2[1] > l2[4])
        begin
            l3[1] = l2[4];
            l3[4] = l2[1];
        end
        // level 4: (0,3)
        l4 = l3;
        if (l3[0] > l3[3])
        begin
            l4[0] = l3[3];
            l4[3] = l3[0];
        end
        // level 5: (0,2) (1,3) then (1,2)
        l5 = l4;
        if (l4[0] > l4[2])
        begin
            l5[0] = l4[2];
            l5[2] = l4[0];
        end
        if (l4[1] > l4[3])
        begin
            l5[1] = l4[3];
            l5[3] = l4[1];
        end
        dout = l5;
        if (l5[1] > l5[2])
        begin
            dout[1] = l5[2];
            dout[2] = l5[1];
        end
    end

endmodule

### sv/tsrf_checker.sv
// ----------------------------------------------------------------------------
// tsrf_checker: port-level checks of the touch sample rank filter
// Report channel handshake, pen code range and event-to-report latency.
// ----------------------------------------------------------------------------
module tsrf_checker
    import tsrf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       ev_valid,
    input logic       ev_ready,
    input logic       rep_valid,
    input logic       rep_ready,
    input sample_t    rep_x,
    input sample_t    rep_y,
    input logic [1:0] rep_code
);

    // hold a stalled report
    a_rep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=> rep_valid)
        else $error("report dropped while stalled");

    a_rep_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=> $stable(rep_x) && $stable(rep_y) && $stable(rep_code))
        else $error("report payload changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid |-> (rep_code == PEN_UP || rep_code == PEN_TOUCH || rep_code == PEN_LONG))
        else $error("reserved pen code reported");

    // a fresh report follows an event transaction through the input and report registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rep_valid) |-> $past(ev_valid && ev_ready, 2))
        else $error("report without a matching event transaction");

endmodule

bind touch_sample_rank_filter tsrf_checker u_tsrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (events.valid),
    .ev_ready  (events.ready),
    .rep_valid (reports.valid),
    .rep_ready (reports.ready),
    .rep_x     (reports.report_x),
    .rep_y     (reports.report_y),
    .rep_code  (reports.pen_code)
);

### tb/sv/touch_sample_rank_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_sample_rank_filter_tb: self-checking bench of the touch rank filter
// Feeds contact events, coordinate samples and ticks through the event
// channel under random idling on both sides, predicts each report with an
// in-bench copy of the filter state and compares every report field by field.
// ----------------------------------------------------------------------------
module touch_sample_rank_filter_tb;
    import tsrf_pkg::*;

    localparam int IDLE_PCT   = 20;    // chance per cycle that a side idles
    localparam int QUIET_LIMIT = 4000; // cycles with no transaction before giving up
    localparam int SETTLE_CYCLES = 6;  // pipeline depth is two, leave margin

    typedef struct packed {
        kind_t   kind;
        sample_t x;
        sample_t y;
    } touch_event_t;

    typedef struct packed {
        sample_t   x;
        sample_t   y;
        pen_code_t code;
    } pen_report_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    tsrf_event_if  ev ();
    tsrf_report_if rpt ();

    touch_sample_rank_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (ev),
        .reports   (rpt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus waiting for the driver and reports waiting for the monitor
    touch_event_t pending_events[$];
    pen_report_t  expected_reports[$];

    bit no_idle;        // set during the saturation stretch: both sides run flat out
    int mismatches;
    int quiet_cycles;

    // Shadow of the filter: configuration and state as the block should hold them
    hold_t   hold_limit;
    warm_t   warmup_count;
    sample_t win_x [WIN_DEPTH];
    sample_t win_y [WIN_DEPTH];
    ptr_t    ring_ptr;
    warm_t   warm_left;
    bit      contact;
    sample_t last_x;
    sample_t last_y;
    hold_t   hold_ticks;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Sort one window ascending; only the multiset matters since the result
    // of an ascending sort is unique up to equal values.
    function automatic void sort_ascending(ref sample_t w [WIN_DEPTH]);
        sample_t t;
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            for (int j = 0; j < WIN_DEPTH - 1 - i; j++)
            begin
                if (w[j] > w[j+1])
                begin
                    t      = w[j];
                    w[j]   = w[j+1];
                    w[j+1] = t;
                end
            end
        end
    endfunction

    // Advance the shadow by one accepted event and queue the report it causes
    function automatic void filter_step(input touch_event_t e);
        pen_report_t r;
        ptr_t        p;
        bit          emit;
        emit = 1'b0;
        case (e.kind)
            KIND_CONTACT:
            begin
                if (!contact)
                begin
                    // Pen up: restart warm-up from slot 0
                    ring_ptr  = '0;
                    warm_left = warmup_count;
                end
                else
                begin
                    // Pen down: release, report only if warm-up had finished
                    contact = 1'b0;
                    if (warm_left == '0)
                    begin
                        r    = '{x: last_x, y: last_y, code: PEN_UP};
                        emit = 1'b1;
                    end
                end
            end
            KIND_SAMPLE:
            begin
                p = (ring_ptr >= WIN_DEPTH) ? '0 : ring_ptr;
                contact = 1'b1;
                win_x[p] = e.x;
                win_y[p] = e.y;
                ring_ptr = (p == WIN_DEPTH - 1) ? '0 : ptr_t'(p + 1);
                emit = 1'b1;
                if (warm_left != '0)
                begin
                    warm_left = warm_left - 1'b1;
                    if (warm_left != '0)
                        emit = 1'b0;
                    else
                        hold_ticks = '0;    // warm-up just ended: restart the hold timer
                end
                if (emit)
                begin
                    sort_ascending(win_x);
                    sort_ascending(win_y);
                    last_x = win_x[REPORT_SLOT];
                    last_y = win_y[REPORT_SLOT];
                    r = '{x: last_x, y: last_y,
                          code: (hold_ticks >= hold_limit) ? PEN_LONG : PEN_TOUCH};
                end
            end
            KIND_TICK:
            begin
                // Count every tick, pen up or down; saturate at the top
                if (hold_ticks != '1)
                    hold_ticks = hold_ticks + 1'b1;
            end
            default:
            begin
                // Unused kind: ignored
            end
        endcase
        if (emit)
            expected_reports.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Event driver: present the next pending item, hold it until accepted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_events
        touch_event_t item;
        if (!rst_n)
        begin
            ev.valid <= 1'b0;
        end
        else
        begin
            if (ev.valid && ev.ready)
                filter_step('{kind: kind_t'(ev.kind), x: ev.sample_x, y: ev.sample_y});
            // Advance only when the slot is free or was just taken
            if (!ev.valid || ev.ready)
            begin
                if (pending_events.size() != 0
                    && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    item = pending_events.pop_front();
                    ev.valid    <= 1'b1;
                    ev.kind     <= item.kind;
                    ev.sample_x <= item.x;
                    ev.sample_y <= item.y;
                end
                else
                begin
                    ev.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report monitor: check each accepted report, stall at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_reports
        pen_report_t want;
        if (!rst_n)
        begin
            rpt.ready <= 1'b0;
        end
        else
        begin
            if (rpt.valid && rpt.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected report x=%0d y=%0d pen=%0d", $time,
                             rpt.report_x, rpt.report_y, rpt.pen_code);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (rpt.report_x !== want.x)
                    begin
                        mismatches++;
                        $display("%0t: report_x expected %0d actual %0d", $time,
                                 want.x, rpt.report_x);
                    end
                    if (rpt.report_y !== want.y)
                    begin
                        mismatches++;
                        $display("%0t: report_y expected %0d actual %0d", $time,
                                 want.y, rpt.report_y);
                    end
                    if (rpt.pen_code !== want.code)
                    begin
                        mismatches++;
                        $display("%0t: pen_code expected %0d actual %0d", $time,
                                 want.code, rpt.pen_code);
                    end
                end
            end
            rpt.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ev.valid && ev.ready) || (rpt.valid && rpt.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_event(input kind_t k, input sample_t x, input sample_t y);
        pending_events.push_back('{kind: k, x: x, y: y});
    endfunction

    // Mostly uniform, now and then a rail value
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return sample_t'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
        endcase
    endfunction

    // Hold until the block is idle: nothing queued, nothing in flight, plus
    // the SETTLE_CYCLES margin for an event that produces no report
    task automatic wait_idle();
        while (pending_events.size() != 0 || ev.valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the shadow follows since the block is idle
    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_LONG_HOLD)
            hold_limit = hold_t'(value);
        else
            warmup_count = warm_t'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One touch: contact, a run of samples with ticks mixed in, usually a release.
    // Returns the number of items queued.
    function automatic int queue_gesture();
        int n;
        int count;
        count = 1;
        push_event(KIND_CONTACT, rand_sample(), rand_sample());
        n = $urandom_range(1, int'(warmup_count) + 8);
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(0, 99) < 40)
            begin
                push_event(KIND_TICK, rand_sample(), rand_sample());
                count++;
            end
            push_event(KIND_SAMPLE, rand_sample(), rand_sample());
            count++;
        end
        if ($urandom_range(0, 9) != 0)
        begin
            push_event(KIND_CONTACT, rand_sample(), rand_sample());
            count++;
        end
        return count;
    endfunction

    // Fill the queue with roughly target items: gestures with some noise.
    // Unused kinds go in as noise but do not count.
    task automatic run_random(input int target);
        int queued;
        kind_t k;
        queued = 0;
        @(negedge clk);
        while (queued < target)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                queued += queue_gesture();
            end
            else
            begin
                k = kind_t'($urandom_range(0, 3));
                push_event(k, rand_sample(), rand_sample());
                if (k != KIND_UNUSED)
                    queued++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        ev.valid     = 1'b0;
        ev.kind      = KIND_CONTACT;
        ev.sample_x  = '0;
        ev.sample_y  = '0;
        rpt.ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_LONG_HOLD;
        cfg_data     = '0;
        no_idle      = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;

        // Shadow starts from the reset state
        hold_limit   = hold_t'(75);
        warmup_count = warm_t'(5);
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        ring_ptr   = '0;
        warm_left  = '0;
        contact    = 1'b0;
        last_x     = '0;
        last_y     = '0;
        hold_ticks = '0;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset thresholds (75 ticks, 5 samples)
        @(negedge clk);
        push_event(KIND_SAMPLE,  '1, '0);             // sample with no contact: reports at once
        push_event(KIND_CONTACT, '0, '0);             // release with report
        push_event(KIND_CONTACT, '1, '1);             // contact: warm-up of 5
        push_event(KIND_SAMPLE,  '0, '1);
        push_event(KIND_SAMPLE,  '1, '0);
        push_event(KIND_SAMPLE,  10'h2AA, 10'h155);
        push_event(KIND_CONTACT, '0, '0);             // release during warm-up: silent
        push_event(KIND_UNUSED,  '1, '1);             // ignored
        push_event(KIND_TICK,    '0, '0);
        push_event(KIND_SAMPLE,  10'h155, 10'h2AA);   // warm-up carries on from before
        push_event(KIND_SAMPLE,  10'd512, 10'd511);   // warm-up ends: first report
        push_event(KIND_TICK,    '1, '1);
        push_event(KIND_TICK,    '0, '0);
        push_event(KIND_SAMPLE,  10'd1, 10'd1022);
        push_event(KIND_SAMPLE,  10'd1022, 10'd1);
        push_event(KIND_CONTACT, '0, '0);             // release with last position
        push_event(KIND_CONTACT, '0, '0);             // new contact
        for (int i = 0; i < 6; i++)
            push_event(KIND_SAMPLE, sample_t'(i * 200), sample_t'(1023 - i * 200));
        push_event(KIND_CONTACT, '0, '0);
        wait_idle();

        // Low extremes, then zero thresholds
        write_cfg(CFG_LONG_HOLD, 16'd1);
        write_cfg(CFG_WARMUP, 16'd1);
        run_random(120);
        write_cfg(CFG_LONG_HOLD, 16'd0);
        write_cfg(CFG_WARMUP, 16'd0);
        run_random(120);

        // Stretch with no idling: long warm-up with the ring wrapping, ticks
        // up to the long-hold threshold and past it, then random traffic
        write_cfg(CFG_LONG_HOLD, 16'd40);
        write_cfg(CFG_WARMUP, 16'd7);
        @(negedge clk);
        no_idle = 1'b1;
        push_event(KIND_CONTACT, '0, '0);
        for (int i = 0; i < 7; i++)
            push_event(KIND_SAMPLE, rand_sample(), rand_sample());
        for (int i = 0; i < 39; i++)
            push_event(KIND_TICK, '0, '0);
        push_event(KIND_SAMPLE, rand_sample(), rand_sample());   // one short of long hold
        push_event(KIND_TICK, '0, '0);
        push_event(KIND_SAMPLE, rand_sample(), rand_sample());   // long hold
        for (int i = 0; i < 10; i++)
            push_event(KIND_TICK, '0, '0);
        push_event(KIND_SAMPLE, rand_sample(), rand_sample());   // still long
        push_event(KIND_CONTACT, '0, '0);
        wait_idle();
        run_random(120);
        @(negedge clk);
        no_idle = 1'b0;

        // Random thresholds across the whole warm-up range, upper warm-up extreme too
        write_cfg(CFG_LONG_HOLD, 16'd20);
        write_cfg(CFG_WARMUP, 16'd5);
        run_random(120);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_cfg(CFG_LONG_HOLD, ($urandom_range(0, 7) == 0)
                      ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 30)));
            write_cfg(CFG_WARMUP, 16'($urandom_range(0, 7)));
            run_random(120);
        end

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
